>>> sv/lcsp_pkg.sv
`timescale 1ns / 1ps

package lcsp_pkg;

  // field widths fixed by the stream format
  localparam int CODE_W = 16;
  localparam int LEN_W  = 5;
  localparam int IDX_W  = 8;
  localparam int OFF_W  = 3;
  localparam int CNT_W  = 3;

  // code_len register: reset value and the range it saturates to
  localparam logic [LEN_W-1:0] CODE_LEN_RESET = 5'd8;
  localparam logic [LEN_W-1:0] CODE_LEN_MIN   = 5'd1;
  localparam logic [LEN_W-1:0] CODE_LEN_MAX   = 5'd16;

  // input item
  typedef struct packed {
    logic [CODE_W-1:0] code_value;
    logic              break_flag;
  } in_item_t;

  // result item: one word of up to four stream bytes
  typedef struct packed {
    logic [7:0]       byte_0;
    logic [7:0]       byte_1;
    logic [7:0]       byte_2;
    logic [7:0]       byte_3;
    logic [CNT_W-1:0] byte_count;
    logic             last_word;
  } out_item_t;

  // command from front to back: store writes, then an optional flush
  typedef struct packed {
    logic [IDX_W-1:0] base_idx;     // logical index of the first written byte
    logic [1:0]       wr_cnt;       // bytes to write, 1..3
    logic [7:0]       wr_b0;
    logic [7:0]       wr_b1;
    logic [7:0]       wr_b2;
    logic             flush;
    logic             move_partial; // limit flush: partial byte goes to entry 0
    logic [7:0]       len_byte;     // sub-block length byte
    logic [IDX_W-1:0] rd_cnt;       // stored bytes to send, 1..255
    logic [7:0]       partial;      // byte at the new position
  } cmd_t;

  // queue status seen by both ends
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  // back end sequencer
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_WRITE,
    BK_FLUSH,
    BK_MOVE
  } bk_state_t;

endpackage

>>> sv/lcsp_front.sv
`timescale 1ns / 1ps

module lcsp_front #(
  parameter int FLUSH_LIMIT = 250
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  lcsp_pkg::in_item_t              in_data,
  input  logic                            cfg_we,
  input  logic [lcsp_pkg::LEN_W-1:0]      cfg_wdata,
  input  lcsp_pkg::q_stat_t               q_stat,
  output logic                            q_push,
  output lcsp_pkg::cmd_t                  q_cmd
);

  localparam logic [lcsp_pkg::IDX_W-1:0] LIMIT = lcsp_pkg::IDX_W'(FLUSH_LIMIT);

  logic [lcsp_pkg::LEN_W-1:0]  code_len_r, code_len_nxt;
  logic [lcsp_pkg::IDX_W-1:0]  byte_idx_r, byte_idx_nxt;
  logic [lcsp_pkg::OFF_W-1:0]  bit_off_r, bit_off_nxt;
  logic [7:0]                  partial_r, partial_nxt;

  logic [lcsp_pkg::LEN_W-1:0]  eff_len;
  logic [lcsp_pkg::CODE_W-1:0] code_mask;
  logic [lcsp_pkg::CODE_W-1:0] code;
  logic [22:0]                 shifted;
  logic [7:0]                  keep;
  logic [lcsp_pkg::LEN_W-1:0]  next_pos;
  logic [1:0]                  adv;
  logic [7:0]                  b0, b1, b2;
  logic [lcsp_pkg::IDX_W-1:0]  new_idx;
  logic [7:0]                  partial_new;
  logic                        brk, at_limit, flush, accept;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept;

  // code length saturated to 1..16
  always_comb begin
    if (code_len_r < lcsp_pkg::CODE_LEN_MIN) begin
      eff_len = lcsp_pkg::CODE_LEN_MIN;
    end else if (code_len_r > lcsp_pkg::CODE_LEN_MAX) begin
      eff_len = lcsp_pkg::CODE_LEN_MAX;
    end else begin
      eff_len = code_len_r;
    end
  end

  // place the code at the current bit offset
  always_comb begin
    code_mask = lcsp_pkg::CODE_W'((17'd1 << eff_len) - 17'd1);
    code      = in_data.code_value & code_mask;
    shifted   = {7'd0, code} << bit_off_r;
    keep      = 8'((9'd1 << bit_off_r) - 9'd1);
    next_pos  = {2'd0, bit_off_r} + eff_len;
    adv       = next_pos[4:3];
    b0        = (partial_r & keep) | shifted[7:0];
    b1        = shifted[15:8];
    b2        = {1'b0, shifted[22:16]};
    new_idx   = byte_idx_r + {{(lcsp_pkg::IDX_W-2){1'b0}}, adv};
  end

  // byte that now holds the open bit position
  always_comb begin
    case (adv)
      2'd1:    partial_new = b1;
      2'd2:    partial_new = b2;
      default: partial_new = b0;
    endcase
  end

  // flush decision and command
  always_comb begin
    brk      = in_data.break_flag;
    at_limit = new_idx > LIMIT;
    flush    = brk || at_limit;

    q_cmd.base_idx     = byte_idx_r;
    q_cmd.wr_cnt       = adv + 2'd1;
    q_cmd.wr_b0        = b0;
    q_cmd.wr_b1        = b1;
    q_cmd.wr_b2        = b2;
    q_cmd.flush        = flush;
    q_cmd.move_partial = !brk;
    q_cmd.partial      = partial_new;
    if (brk) begin
      q_cmd.len_byte = new_idx + 8'd1;
      q_cmd.rd_cnt   = new_idx + 8'd1;
    end else begin
      q_cmd.len_byte = new_idx;
      q_cmd.rd_cnt   = new_idx;
    end
  end

  // position and register updates
  always_comb begin
    code_len_nxt = cfg_we ? cfg_wdata : code_len_r;
    byte_idx_nxt = byte_idx_r;
    bit_off_nxt  = bit_off_r;
    partial_nxt  = partial_r;
    if (accept) begin
      byte_idx_nxt = flush ? '0 : new_idx;
      bit_off_nxt  = brk ? '0 : next_pos[2:0];
      partial_nxt  = partial_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_len_r <= lcsp_pkg::CODE_LEN_RESET;
      byte_idx_r <= '0;
      bit_off_r  <= '0;
    end else begin
      code_len_r <= code_len_nxt;
      byte_idx_r <= byte_idx_nxt;
      bit_off_r  <= bit_off_nxt;
    end
  end

  // partial byte only matters once a code has been written
  always_ff @(posedge clk) begin
    partial_r <= partial_nxt;
  end

endmodule

>>> sv/lcsp_cmd_fifo.sv
`timescale 1ns / 1ps

module lcsp_cmd_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  lcsp_pkg::cmd_t    push_cmd,
  input  logic              pop,
  output lcsp_pkg::cmd_t    head_cmd,
  output lcsp_pkg::q_stat_t stat
);

  lcsp_pkg::cmd_t entry_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;

  assign stat.empty = (cnt_r == 2'd0);
  assign stat.full  = (cnt_r == 2'd2);
  assign head_cmd   = entry_r[rd_ptr_r];

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

>>> sv/lcsp_back.sv
`timescale 1ns / 1ps

module lcsp_back #(
  parameter int BLOCK_DEPTH = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lcsp_pkg::q_stat_t   q_stat,
  input  lcsp_pkg::cmd_t      q_cmd,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output lcsp_pkg::out_item_t out_data
);

  localparam int         AW     = $clog2(BLOCK_DEPTH);
  localparam logic [8:0] DEPTH9 = 9'(BLOCK_DEPTH);

  // logical byte index to store address; index stays below 257 and depth is 64 or more
  function automatic logic [AW-1:0] wrap_addr(input logic [8:0] a);
    logic [8:0] v;
    v = a;
    for (int i = 0; i < 4; i++) begin
      if (v >= DEPTH9) begin
        v = v - DEPTH9;
      end
    end
    return AW'(v);
  endfunction

  logic [7:0] mem [BLOCK_DEPTH];

  lcsp_pkg::bk_state_t state_r, state_nxt;
  lcsp_pkg::cmd_t      cmd_r, cmd_nxt;
  logic [1:0]          wr_k_r, wr_k_nxt;
  logic [7:0]          rd_ptr_r, rd_ptr_nxt;
  logic                rd_v_r, rd_v_nxt;
  logic                rd_last_r, rd_last_nxt;
  logic [7:0]          rd_data_r;
  logic [2:0][7:0]     asm_r, asm_nxt;
  logic [1:0]          asm_cnt_r, asm_cnt_nxt;
  lcsp_pkg::out_item_t out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic                load_cmd, flush_start;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [7:0]          mem_wdata;
  logic                wr_last, byte_v, emit, out_free, consume, more, issue, done_flush;
  lcsp_pkg::out_item_t word;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // flush stream handshake: one byte per cycle through the read register while the output is not stalled
  always_comb begin
    wr_last    = (wr_k_r == cmd_r.wr_cnt - 2'd1);
    byte_v     = (state_r == lcsp_pkg::BK_FLUSH) && rd_v_r;
    emit       = byte_v && ((asm_cnt_r == 2'd3) || rd_last_r);
    out_free   = !out_valid_r || out_ready;
    consume    = byte_v && (!emit || out_free);
    more       = (rd_ptr_r != cmd_r.rd_cnt);
    issue      = (state_r == lcsp_pkg::BK_FLUSH) && more && (!rd_v_r || consume);
    done_flush = consume && rd_last_r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lcsp_pkg::BK_IDLE: begin
        if (!q_stat.empty) state_nxt = lcsp_pkg::BK_WRITE;
      end
      lcsp_pkg::BK_WRITE: begin
        if (wr_last) begin
          if (cmd_r.flush) begin
            state_nxt = lcsp_pkg::BK_FLUSH;
          end else if (q_stat.empty) begin
            state_nxt = lcsp_pkg::BK_IDLE;
          end
        end
      end
      lcsp_pkg::BK_FLUSH: begin
        if (done_flush) begin
          state_nxt = cmd_r.move_partial ? lcsp_pkg::BK_MOVE : lcsp_pkg::BK_IDLE;
        end
      end
      lcsp_pkg::BK_MOVE: begin
        state_nxt = lcsp_pkg::BK_IDLE;
      end
      default: state_nxt = lcsp_pkg::BK_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    load_cmd    = 1'b0;
    flush_start = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = cmd_r.partial;
    unique case (state_r)
      lcsp_pkg::BK_IDLE: begin
        load_cmd = !q_stat.empty;
      end
      lcsp_pkg::BK_WRITE: begin
        mem_we      = 1'b1;
        mem_waddr   = wrap_addr({1'b0, cmd_r.base_idx} + {7'd0, wr_k_r});
        case (wr_k_r)
          2'd1:    mem_wdata = cmd_r.wr_b1;
          2'd2:    mem_wdata = cmd_r.wr_b2;
          default: mem_wdata = cmd_r.wr_b0;
        endcase
        flush_start = wr_last && cmd_r.flush;
        load_cmd    = wr_last && !cmd_r.flush && !q_stat.empty;
      end
      lcsp_pkg::BK_FLUSH: begin
      end
      lcsp_pkg::BK_MOVE: begin
        // carried-over partial byte lands at entry 0
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = cmd_r.partial;
      end
      default: begin
      end
    endcase
  end

  assign q_pop = load_cmd;

  // word built from the held bytes plus the arriving one, spare lanes zero
  always_comb begin
    word.byte_0     = (asm_cnt_r > 2'd0) ? asm_r[0] : rd_data_r;
    word.byte_1     = (asm_cnt_r > 2'd1) ? asm_r[1] :
                      (asm_cnt_r == 2'd1) ? rd_data_r : 8'd0;
    word.byte_2     = (asm_cnt_r > 2'd2) ? asm_r[2] :
                      (asm_cnt_r == 2'd2) ? rd_data_r : 8'd0;
    word.byte_3     = (asm_cnt_r == 2'd3) ? rd_data_r : 8'd0;
    word.byte_count = {1'b0, asm_cnt_r} + 3'd1;
    word.last_word  = rd_last_r;
  end

  // datapath next values
  always_comb begin
    cmd_nxt       = load_cmd ? q_cmd : cmd_r;
    wr_k_nxt      = wr_k_r;
    rd_ptr_nxt    = rd_ptr_r;
    rd_v_nxt      = rd_v_r;
    rd_last_nxt   = rd_last_r;
    asm_nxt       = asm_r;
    asm_cnt_nxt   = asm_cnt_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;

    if (load_cmd) begin
      wr_k_nxt = 2'd0;
    end else if ((state_r == lcsp_pkg::BK_WRITE) && !wr_last) begin
      wr_k_nxt = wr_k_r + 2'd1;
    end

    // read side
    if (flush_start) begin
      rd_ptr_nxt = '0;
      rd_v_nxt   = 1'b0;
    end else if (issue) begin
      rd_ptr_nxt  = rd_ptr_r + 8'd1;
      rd_v_nxt    = 1'b1;
      rd_last_nxt = (rd_ptr_r == cmd_r.rd_cnt - 8'd1);
    end else if (consume) begin
      rd_v_nxt = 1'b0;
    end

    // byte assembly; the length byte opens every sub-block
    if (flush_start) begin
      asm_nxt[0]  = cmd_r.len_byte;
      asm_cnt_nxt = 2'd1;
    end else if (consume) begin
      if (emit) begin
        asm_cnt_nxt = 2'd0;
      end else begin
        asm_nxt[asm_cnt_r] = rd_data_r;
        asm_cnt_nxt        = asm_cnt_r + 2'd1;
      end
    end

    // output register
    if (emit && consume) begin
      out_nxt       = word;
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lcsp_pkg::BK_IDLE;
      wr_k_r      <= 2'd0;
      rd_ptr_r    <= '0;
      rd_v_r      <= 1'b0;
      asm_cnt_r   <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_k_r      <= wr_k_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      rd_v_r      <= rd_v_nxt;
      asm_cnt_r   <= asm_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    rd_last_r <= rd_last_nxt;
    asm_r     <= asm_nxt;
    out_r     <= out_nxt;
  end

  // byte store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data_r <= mem[wrap_addr({1'b0, rd_ptr_r})];
    end
  end

endmodule

>>> sv/lzw_code_subblock_packer.sv
`timescale 1ns / 1ps

// Port group | Direction | Handshake             | Payload
// in_        | input     | in_valid / in_ready   | lcsp_pkg::in_item_t: code_value, break_flag
// out_       | output    | out_valid / out_ready | lcsp_pkg::out_item_t: byte_0..3, count, last
// cfg_       | input     | cfg_we, no wait       | cfg_wdata: code_len, 5 bits
//
// A code is taken while in_ready is high; the back end writes its 1 to 3 bytes
// at one per cycle, after a command load in its idle state when it starts from idle.
// A flush of n stored bytes streams one byte per cycle while out_ready is high; a limit
// flush adds a carry-over write to entry 0; a low out_ready stalls it.
// Reset is synchronous, active low; the byte store is not cleared.
// A two-item command queue lets input continue while a flush drains or out_ready is low.

module lzw_code_subblock_packer #(
  parameter int BLOCK_DEPTH = 256,
  parameter int FLUSH_LIMIT = 250
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  lcsp_pkg::in_item_t         in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output lcsp_pkg::out_item_t        out_data,
  input  logic                       cfg_we,
  input  logic [lcsp_pkg::LEN_W-1:0] cfg_wdata
);

  lcsp_pkg::q_stat_t q_stat;
  lcsp_pkg::cmd_t    push_cmd;
  lcsp_pkg::cmd_t    head_cmd;
  logic              q_push;
  logic              q_pop;

  // packing position and flush decision
  lcsp_front #(
    .FLUSH_LIMIT (FLUSH_LIMIT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  lcsp_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .stat     (q_stat)
  );

  // byte store and sub-block output
  lcsp_back #(
    .BLOCK_DEPTH (BLOCK_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_cmd     (head_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // a short word can only close a sub-block
  a_short_word_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.byte_count != 3'd4) |-> out_data.last_word)
    else $error("short word before end of sub-block");

  // count is always 1..4
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.byte_count != 3'd0) && (out_data.byte_count <= 3'd4))
    else $error("byte count out of range");

  // lanes past the count carry zero; checked for a one-byte word
  a_spare_lanes_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.byte_count == 3'd1) |->
      (out_data.byte_1 == 8'd0) && (out_data.byte_2 == 8'd0) && (out_data.byte_3 == 8'd0))
    else $error("spare lanes not zero");

  // the queue never takes an item it has no room for
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !q_push)
    else $error("command queue overflow");
`endif

endmodule
